// ===== rtl/core/c_subset_lexer_defines.svh =====
// Assertion macros shared by the lexer RTL.
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CLX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CLX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/clx_pkg.sv =====
// Package: types, token codes, keyword table and character helpers for the lexer.
`default_nettype none

package clx_pkg;

	localparam int MAX_TOKEN_LEN = 255;
	localparam int POSITION_BITS = 16;

	localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);
	localparam logic [7:0] WORD_BYTES = 8'd6;
	localparam int KW_COUNT = 13;

	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_DQUOTE = 8'd34;

	// token classes
	localparam logic [5:0] KIND_IDENT  = 6'd0;
	localparam logic [5:0] KIND_INT    = 6'd1;
	localparam logic [5:0] KIND_CHAR   = 6'd2;
	localparam logic [5:0] KIND_STR    = 6'd3;
	localparam logic [5:0] KIND_KW0    = 6'd4;
	localparam logic [5:0] KIND_PLUS   = 6'd17;
	localparam logic [5:0] KIND_MINUS  = 6'd18;
	localparam logic [5:0] KIND_MULT   = 6'd19;
	localparam logic [5:0] KIND_DIV    = 6'd20;
	localparam logic [5:0] KIND_LSS    = 6'd21;
	localparam logic [5:0] KIND_LEQ    = 6'd22;
	localparam logic [5:0] KIND_GRE    = 6'd23;
	localparam logic [5:0] KIND_GEQ    = 6'd24;
	localparam logic [5:0] KIND_EQL    = 6'd25;
	localparam logic [5:0] KIND_NEQ    = 6'd26;
	localparam logic [5:0] KIND_ASSIGN = 6'd27;
	localparam logic [5:0] KIND_SEMI   = 6'd28;
	localparam logic [5:0] KIND_COMMA  = 6'd29;
	localparam logic [5:0] KIND_LPAREN = 6'd30;
	localparam logic [5:0] KIND_RPAREN = 6'd31;
	localparam logic [5:0] KIND_LBRACK = 6'd32;
	localparam logic [5:0] KIND_RBRACK = 6'd33;
	localparam logic [5:0] KIND_LBRACE = 6'd34;
	localparam logic [5:0] KIND_RBRACE = 6'd35;
	localparam logic [5:0] KIND_LAST   = KIND_RBRACE;

	// keyword spellings, first char in the low byte, zero padded
	localparam logic [47:0] KW_WORDS [KW_COUNT] = '{
		48'h0074_736E_6F63, // const
		48'h0000_0074_6E69, // int
		48'h0000_7261_6863, // char
		48'h0000_6469_6F76, // void
		48'h0000_6E69_616D, // main
		48'h0000_0000_6669, // if
		48'h0000_6573_6C65, // else
		48'h0000_0000_6F64, // do
		48'h0065_6C69_6877, // while
		48'h0000_0072_6F66, // for
		48'h0066_6E61_6373, // scanf
		48'h6674_6E69_7270, // printf
		48'h6E72_7574_6572  // return
	};

	typedef enum logic [9:0] {
		MODE_IDLE  = 10'b00_0000_0001,
		MODE_IDENT = 10'b00_0000_0010,
		MODE_NUM   = 10'b00_0000_0100,
		MODE_CQ    = 10'b00_0000_1000,
		MODE_CB    = 10'b00_0001_0000,
		MODE_STR   = 10'b00_0010_0000,
		MODE_LT    = 10'b00_0100_0000,
		MODE_GT    = 10'b00_1000_0000,
		MODE_EQ    = 10'b01_0000_0000,
		MODE_BANG  = 10'b10_0000_0000
	} clx_mode_t;

	typedef struct packed {
		logic        valid;
		logic [5:0]  kind;
		logic [15:0] start;
		logic [7:0]  len;
		logic        last;
	} clx_token_t;

	// up to two tokens per source byte, in emission order
	typedef struct packed {
		clx_token_t first;
		clx_token_t second;
	} clx_pair_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c == "_") || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic [5:0] kw_kind(input logic [47:0] word, input logic ovf);
		logic [5:0] kind;
		kind = KIND_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!ovf && (word == KW_WORDS[k]))
				kind = KIND_KW0 + 6'(k);
		end
		return kind;
	endfunction

	function automatic clx_token_t make_token(input logic [5:0] kind,
		input logic [15:0] start, input logic [7:0] len);
		clx_token_t t;
		t.valid = 1'b1;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.last  = 1'b0;
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clx_lex_core.sv =====
// Lexer state registers and the single-pass next-state and token logic.
`default_nettype none

module clx_lex_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [7:0]       byte_c,
	input  wire logic             fin,
	output clx_pkg::clx_pair_t    pair
);

	clx_pkg::clx_mode_t                   mode_q, mode_n;
	logic [47:0]                          word_q, word_n;
	logic                                 ovf_q, ovf_n;
	logic [clx_pkg::POSITION_BITS-1:0]    start_q, start_n;
	logic [7:0]                           len_q, len_n;
	logic [clx_pkg::POSITION_BITS-1:0]    pos_q;
	clx_pkg::clx_token_t                  e_cont, e_start, e_fin;
	logic                                 consumed;

	always_comb begin
		mode_n   = mode_q;
		word_n   = word_q;
		ovf_n    = ovf_q;
		start_n  = start_q;
		len_n    = len_q;
		consumed = 1'b0;
		e_cont   = '0;
		e_start  = '0;
		e_fin    = '0;

		// pending token sees the byte first
		unique case (mode_q)
			clx_pkg::MODE_IDENT: begin
				if (clx_pkg::is_alpha(byte_c) || clx_pkg::is_digit(byte_c)) begin
					consumed = 1'b1;
					if (len_q < clx_pkg::WORD_BYTES)
						word_n = word_q | ({40'b0, byte_c} << {len_q[2:0], 3'b000});
					else
						ovf_n = 1'b1;
					if (len_q != clx_pkg::LEN_CAP)
						len_n = len_q + 8'd1;
				end else begin
					e_cont = clx_pkg::make_token(clx_pkg::kw_kind(word_q, ovf_q),
						16'(start_q), len_q);
					mode_n = clx_pkg::MODE_IDLE;
					word_n = '0;
					ovf_n  = 1'b0;
				end
			end
			clx_pkg::MODE_NUM: begin
				if (clx_pkg::is_digit(byte_c)) begin
					consumed = 1'b1;
					if (len_q != clx_pkg::LEN_CAP)
						len_n = len_q + 8'd1;
				end else begin
					e_cont = clx_pkg::make_token(clx_pkg::KIND_INT, 16'(start_q), len_q);
					mode_n = clx_pkg::MODE_IDLE;
					word_n = '0;
					ovf_n  = 1'b0;
				end
			end
			clx_pkg::MODE_CQ: begin
				consumed = 1'b1;
				start_n  = pos_q;
				mode_n   = clx_pkg::MODE_CB;
			end
			clx_pkg::MODE_CB: begin
				// a malformed constant just drops out here
				consumed = 1'b1;
				if (byte_c == clx_pkg::CH_SQUOTE)
					e_cont = clx_pkg::make_token(clx_pkg::KIND_CHAR, 16'(start_q), 8'd1);
				mode_n = clx_pkg::MODE_IDLE;
			end
			clx_pkg::MODE_STR: begin
				consumed = 1'b1;
				if (byte_c == clx_pkg::CH_DQUOTE) begin
					e_cont = clx_pkg::make_token(clx_pkg::KIND_STR, 16'(start_q), len_q);
					mode_n = clx_pkg::MODE_IDLE;
				end else if (len_q != clx_pkg::LEN_CAP) begin
					len_n = len_q + 8'd1;
				end
			end
			clx_pkg::MODE_LT, clx_pkg::MODE_GT, clx_pkg::MODE_EQ, clx_pkg::MODE_BANG: begin
				if (byte_c == "=") begin
					consumed = 1'b1;
					priority case (mode_q)
						clx_pkg::MODE_LT: e_cont = clx_pkg::make_token(clx_pkg::KIND_LEQ,
							16'(start_q), 8'd2);
						clx_pkg::MODE_GT: e_cont = clx_pkg::make_token(clx_pkg::KIND_GEQ,
							16'(start_q), 8'd2);
						clx_pkg::MODE_EQ: e_cont = clx_pkg::make_token(clx_pkg::KIND_EQL,
							16'(start_q), 8'd2);
						default:          e_cont = clx_pkg::make_token(clx_pkg::KIND_NEQ,
							16'(start_q), 8'd2);
					endcase
				end else begin
					// lone bang gives nothing
					priority case (mode_q)
						clx_pkg::MODE_LT: e_cont = clx_pkg::make_token(clx_pkg::KIND_LSS,
							16'(start_q), 8'd1);
						clx_pkg::MODE_GT: e_cont = clx_pkg::make_token(clx_pkg::KIND_GRE,
							16'(start_q), 8'd1);
						clx_pkg::MODE_EQ: e_cont = clx_pkg::make_token(clx_pkg::KIND_ASSIGN,
							16'(start_q), 8'd1);
						default:          e_cont = '0;
					endcase
					word_n = '0;
					ovf_n  = 1'b0;
				end
				mode_n = clx_pkg::MODE_IDLE;
			end
			default: begin
				mode_n = clx_pkg::MODE_IDLE;
			end
		endcase

		// byte not taken by the pending token: maybe it opens a new one
		if (!consumed && !clx_pkg::is_space(byte_c)) begin
			start_n = pos_q;
			len_n   = '0;
			word_n  = '0;
			ovf_n   = 1'b0;
			priority if (clx_pkg::is_alpha(byte_c)) begin
				mode_n = clx_pkg::MODE_IDENT;
				word_n = {40'b0, byte_c};
				len_n  = 8'd1;
			end else if (clx_pkg::is_digit(byte_c)) begin
				mode_n = clx_pkg::MODE_NUM;
				len_n  = 8'd1;
			end else if (byte_c == clx_pkg::CH_SQUOTE) begin
				mode_n = clx_pkg::MODE_CQ;
			end else if (byte_c == clx_pkg::CH_DQUOTE) begin
				mode_n  = clx_pkg::MODE_STR;
				start_n = pos_q + 1'b1;
			end else if (byte_c == "<") begin
				mode_n = clx_pkg::MODE_LT;
			end else if (byte_c == ">") begin
				mode_n = clx_pkg::MODE_GT;
			end else if (byte_c == "=") begin
				mode_n = clx_pkg::MODE_EQ;
			end else if (byte_c == "!") begin
				mode_n = clx_pkg::MODE_BANG;
			end else begin
				unique case (byte_c)
					"+": e_start = clx_pkg::make_token(clx_pkg::KIND_PLUS,   16'(pos_q), 8'd1);
					"-": e_start = clx_pkg::make_token(clx_pkg::KIND_MINUS,  16'(pos_q), 8'd1);
					"*": e_start = clx_pkg::make_token(clx_pkg::KIND_MULT,   16'(pos_q), 8'd1);
					"/": e_start = clx_pkg::make_token(clx_pkg::KIND_DIV,    16'(pos_q), 8'd1);
					";": e_start = clx_pkg::make_token(clx_pkg::KIND_SEMI,   16'(pos_q), 8'd1);
					",": e_start = clx_pkg::make_token(clx_pkg::KIND_COMMA,  16'(pos_q), 8'd1);
					"(": e_start = clx_pkg::make_token(clx_pkg::KIND_LPAREN, 16'(pos_q), 8'd1);
					")": e_start = clx_pkg::make_token(clx_pkg::KIND_RPAREN, 16'(pos_q), 8'd1);
					"[": e_start = clx_pkg::make_token(clx_pkg::KIND_LBRACK, 16'(pos_q), 8'd1);
					"]": e_start = clx_pkg::make_token(clx_pkg::KIND_RBRACK, 16'(pos_q), 8'd1);
					"{": e_start = clx_pkg::make_token(clx_pkg::KIND_LBRACE, 16'(pos_q), 8'd1);
					"}": e_start = clx_pkg::make_token(clx_pkg::KIND_RBRACE, 16'(pos_q), 8'd1);
					default: e_start = '0; // unknown byte, ignored
				endcase
			end
		end

		// end of text: flush what can be flushed, drop the rest
		if (fin) begin
			unique case (mode_n)
				clx_pkg::MODE_IDENT: e_fin = clx_pkg::make_token(
					clx_pkg::kw_kind(word_n, ovf_n), 16'(start_n), len_n);
				clx_pkg::MODE_NUM: e_fin = clx_pkg::make_token(clx_pkg::KIND_INT,
					16'(start_n), len_n);
				clx_pkg::MODE_LT: e_fin = clx_pkg::make_token(clx_pkg::KIND_LSS,
					16'(start_n), 8'd1);
				clx_pkg::MODE_GT: e_fin = clx_pkg::make_token(clx_pkg::KIND_GRE,
					16'(start_n), 8'd1);
				clx_pkg::MODE_EQ: e_fin = clx_pkg::make_token(clx_pkg::KIND_ASSIGN,
					16'(start_n), 8'd1);
				default: e_fin = '0;
			endcase
			mode_n = clx_pkg::MODE_IDLE;
			word_n = '0;
			ovf_n  = 1'b0;
			len_n  = '0;
		end

		// pack in order; a single-char op never coexists with a flush
		pair.first  = e_cont.valid ? e_cont : (e_start.valid ? e_start : e_fin);
		pair.second = e_cont.valid ? (e_start.valid ? e_start : e_fin) : '0;
		pair.first.last  = !pair.second.valid;
		pair.second.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= clx_pkg::MODE_IDLE;
			word_q  <= '0;
			ovf_q   <= 1'b0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (go) begin
			mode_q  <= mode_n;
			word_q  <= word_n;
			ovf_q   <= ovf_n;
			start_q <= start_n;
			len_q   <= len_n;
			pos_q   <= pos_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/clx_result_buf.sv =====
// Two-slot result register: shows one token at a time, second slot drains next.
`default_nettype none

module clx_result_buf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire clx_pkg::clx_pair_t   pair,
	input  wire logic                 pop,
	output clx_pkg::clx_token_t       head,
	output logic                      second_valid
);

	logic                v0_q, v1_q;
	clx_pkg::clx_token_t slot0_q, slot1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (load) begin
			v0_q <= pair.first.valid;
			v1_q <= pair.second.valid;
		end else if (pop) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= pair.first;
			slot1_q <= pair.second;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	always_comb begin
		head       = slot0_q;
		head.valid = v0_q;
	end

	assign second_valid = v1_q;

endmodule

`default_nettype wire

// ===== rtl/core/c_subset_lexer.sv =====
// Top level: byte input register, lexer core and token result register.
// Order: a byte in the input register is lexed at the edge when the result register is free;
//   its first token is on the port right after it, a second one once the first is taken.
// Throughput: one byte per cycle while each byte yields at most one token and tokens are
//   taken at once; a byte that yields two tokens holds the next byte while its second waits.
// Reset (arst_n low, asynchronous): lexer idle, offsets and counts zero, no requests held.
`default_nettype none
`include "c_subset_lexer_defines.svh"

module c_subset_lexer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// source byte channel
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [7:0]  source_byte,
	input  wire logic        final_byte,
	// token channel
	output logic             tok_valid,
	input  wire logic        tok_stall,
	output logic [5:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [7:0]       token_length,
	output logic             last_of_run
);

	// input register: parts the source side from the lexer
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 fin_s1;

	logic                 src_take;
	logic                 tok_take;
	logic                 go;          // lexer consumes the held byte this cycle
	logic                 second_valid;
	clx_pkg::clx_pair_t   pair;
	clx_pkg::clx_token_t  head;
	logic                 tok_two_char; // shown token is a two-character operator

	assign src_take = src_valid && !src_stall;
	assign tok_take = tok_valid && !tok_stall;

	// The result register must be empty after this edge before a new pair lands in it:
	// either nothing is shown, or the last shown token is being taken now.
	assign go = valid_s1 && (!head.valid || (!second_valid && tok_take));

	// A byte waits in the input register while the result side is full.
	assign src_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= src_take || (valid_s1 && !go);
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			byte_s1 <= source_byte;
			fin_s1  <= final_byte;
		end
	end

	// whole byte lexed in one pass: pending token, new token, end-of-text flush
	clx_lex_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.byte_c (byte_s1),
		.fin    (fin_s1),
		.pair   (pair)
	);

	clx_result_buf u_rbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (go),
		.pair         (pair),
		.pop          (tok_take),
		.head         (head),
		.second_valid (second_valid)
	);

	assign tok_valid    = head.valid;
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.len;
	assign last_of_run  = head.last;

	assign tok_two_char = (token_kind == clx_pkg::KIND_LEQ) || (token_kind == clx_pkg::KIND_GEQ)
		|| (token_kind == clx_pkg::KIND_EQL) || (token_kind == clx_pkg::KIND_NEQ);

	// second slot only ever backs up a shown first slot
	`CLX_ASSERT_NOW(a_slot_order, second_valid, tok_valid, "second token held without a first")

	// a lexed byte that yields a token shows it on the next cycle
	`CLX_ASSERT_NEXT(a_token_shown, go && pair.first.valid, tok_valid, "token lost after lexing")

	// class code stays in range
	`CLX_ASSERT_NOW(a_kind_range, tok_valid, token_kind <= clx_pkg::KIND_LAST, "bad token class")

	// two-character operators carry both characters
	`CLX_ASSERT_NOW(a_pair_len, tok_valid && tok_two_char, token_length == 8'd2, "bad op length")

endmodule

`default_nettype wire
